>>> src/rmth_pkg.sv
// Package for the running median block: default sizes, sequencer state type
// and heap side codes. No dependencies.
`default_nettype none
package rmth_pkg;
	localparam int DefHalfCapacity = 128;
	localparam int DefSampleWidth  = 16;

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_POP_RD  = 8'b0000_0010,
		S_POP_WT  = 8'b0000_0100,
		S_INS_CHK = 8'b0000_1000,
		S_INS_CMP = 8'b0001_0000,
		S_TOP_RD  = 8'b0010_0000,
		S_TOP_WT  = 8'b0100_0000,
		S_FIN     = 8'b1000_0000
	} state_t;

	typedef enum logic {
		SIDE_LO = 1'b0,
		SIDE_UP = 1'b1
	} side_t;
endpackage
`default_nettype wire

>>> src/running_median_two_heaps_top.sv
// Running median top level: sequencer over two sorted heap memories.
// Depends on rmth_pkg and rmth_mem.
//
// Usage:
// - Input channel (in_valid/in_ready) carries one sample and a new_stream
//   flag; new_stream empties both heaps and zeroes the median first.
// - Output channel (out_valid/out_ready) gives one median and overflow flag
//   per input item, in order.
// - One item at a time. An item passes through an accept step, an insert
//   (a compare for each entry shifted, none at the bottom of a heap), a move
//   of a top across heaps where needed, the top reads and a load of the
//   output register. The insertion shift goes through the single read port
//   of each heap memory.
// - A full store (2*HALF_CAPACITY samples) drops the sample, repeats the
//   old median and sets overflow.
// - Reset empties both heaps and zeroes the median; heap memories are not
//   cleared, only entries below the counts are ever used.
// - A stalled receiver holds the result in the output register; the next
//   item is accepted meanwhile and waits at its end until the register frees.
`default_nettype none
module running_median_two_heaps_top import rmth_pkg::*; #(
	parameter int HALF_CAPACITY = DefHalfCapacity,
	parameter int SAMPLE_WIDTH  = DefSampleWidth
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
	input  wire logic                           new_stream,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed      [SAMPLE_WIDTH-1:0] median,
	output logic                                overflow
);
	localparam int AW = $clog2(HALF_CAPACITY);
	localparam int CW = $clog2(HALF_CAPACITY + 1);
	localparam int W  = SAMPLE_WIDTH;

	state_t state_q;
	logic [CW-1:0] lc_q, uc_q, idx_q;
	logic signed [W-1:0] med_q, x_q, ins_val_q;
	side_t ins_side_q, pop_side_q, join_side_q;
	logic pend_q, both_q, ovf_q;

	logic lo_we, up_we;
	logic [AW-1:0] lo_waddr, up_waddr, lo_raddr, up_raddr;
	logic [W-1:0] wdata, lo_rdata, up_rdata;

	rmth_mem #(.DEPTH(HALF_CAPACITY), .WIDTH(W)) u_lo (
		.clk(clk), .we(lo_we), .waddr(lo_waddr), .wdata(wdata),
		.raddr(lo_raddr), .rdata(lo_rdata));
	rmth_mem #(.DEPTH(HALF_CAPACITY), .WIDTH(W)) u_up (
		.clk(clk), .we(up_we), .waddr(up_waddr), .wdata(wdata),
		.raddr(up_raddr), .rdata(up_rdata));

	logic signed [W-1:0] lo_d, up_d, ins_d;
	logic [CW-1:0] lc_m1, uc_m1, idx_m1;
	logic ins_move, ins_done;
	logic signed [W:0] sum, adj;
	logic signed [W-1:0] avg;
	logic out_load;

	assign lo_d   = lo_rdata;
	assign up_d   = up_rdata;
	assign ins_d  = (ins_side_q == SIDE_UP) ? up_d : lo_d;
	assign lc_m1  = lc_q - CW'(1);
	assign uc_m1  = uc_q - CW'(1);
	assign idx_m1 = idx_q - CW'(1);
	assign ins_move = (state_q == S_INS_CMP) &&
		((ins_side_q == SIDE_LO) ? (ins_d > ins_val_q) : (ins_d < ins_val_q));
	assign ins_done = ((state_q == S_INS_CHK) && (idx_q == '0)) ||
		((state_q == S_INS_CMP) && !ins_move);
	assign sum = {lo_d[W-1], lo_d} + {up_d[W-1], up_d};
	assign adj = sum + (W+1)'(sum[W]);
	assign avg = W'(adj >>> 1);
	assign in_ready = (state_q == S_IDLE);
	assign out_load = (state_q == S_FIN) && (!out_valid || out_ready);

	always_comb begin
		lo_we = 1'b0;
		up_we = 1'b0;
		lo_waddr = idx_q[AW-1:0];
		up_waddr = idx_q[AW-1:0];
		wdata = ins_move ? ins_d : ins_val_q;
		lo_raddr = '0;
		up_raddr = '0;
		if (ins_done || ins_move) begin
			lo_we = (ins_side_q == SIDE_LO);
			up_we = (ins_side_q == SIDE_UP);
		end
		case (state_q)
			S_POP_RD, S_TOP_RD: begin
				lo_raddr = lc_m1[AW-1:0];
				up_raddr = uc_m1[AW-1:0];
			end
			S_INS_CHK: begin
				lo_raddr = idx_m1[AW-1:0];
				up_raddr = idx_m1[AW-1:0];
			end
			default: ;
		endcase
	end

	logic [CW-1:0] lc0, uc0;
	logic signed [W-1:0] med0;
	logic full0, gt0;

	always_comb begin
		lc0  = new_stream ? '0 : lc_q;
		uc0  = new_stream ? '0 : uc_q;
		med0 = new_stream ? '0 : med_q;
		full0 = ({1'b0, lc0} + {1'b0, uc0}) >= (CW+1)'(2 * HALF_CAPACITY);
		gt0 = sample > med0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lc_q        <= '0;
			uc_q        <= '0;
			idx_q       <= '0;
			med_q       <= '0;
			x_q         <= '0;
			ins_val_q   <= '0;
			ins_side_q  <= SIDE_LO;
			pop_side_q  <= SIDE_LO;
			join_side_q <= SIDE_LO;
			both_q      <= 1'b0;
			out_valid   <= 1'b0;
			median      <= '0;
			overflow    <= 1'b0;
			ovf_q       <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						lc_q  <= lc0;
						uc_q  <= uc0;
						med_q <= med0;
						x_q   <= sample;
						ins_val_q <= sample;
						pend_q <= 1'b0;
						both_q <= (lc0 != uc0);
						join_side_q <= gt0 ? SIDE_UP : SIDE_LO;
						if (full0) begin
							ovf_q   <= 1'b1;
							state_q <= S_FIN;
						end else if ((lc0 > uc0) && !gt0) begin
							pop_side_q <= SIDE_LO;
							state_q <= S_POP_RD;
						end else if ((lc0 < uc0) && gt0) begin
							pop_side_q <= SIDE_UP;
							state_q <= S_POP_RD;
						end else begin
							ins_side_q <= gt0 ? SIDE_UP : SIDE_LO;
							idx_q <= gt0 ? uc0 : lc0;
							state_q <= S_INS_CHK;
						end
					end
				end
				S_POP_RD: state_q <= S_POP_WT;
				S_POP_WT: begin
					pend_q <= 1'b1;
					if (pop_side_q == SIDE_LO) begin
						ins_val_q  <= lo_d;
						ins_side_q <= SIDE_UP;
						idx_q <= uc_q;
						lc_q  <= lc_m1;
					end else begin
						ins_val_q  <= up_d;
						ins_side_q <= SIDE_LO;
						idx_q <= lc_q;
						uc_q  <= uc_m1;
					end
					state_q <= S_INS_CHK;
				end
				S_INS_CHK, S_INS_CMP: begin
					if (ins_move) begin
						idx_q   <= idx_m1;
						state_q <= S_INS_CHK;
					end else if (ins_done) begin
						if (ins_side_q == SIDE_LO) begin
							lc_q <= lc_q + CW'(1);
						end else begin
							uc_q <= uc_q + CW'(1);
						end
						if (pend_q) begin
							pend_q     <= 1'b0;
							ins_side_q <= pop_side_q;
							ins_val_q  <= x_q;
							idx_q   <= (pop_side_q == SIDE_LO) ? lc_q : uc_q;
							state_q <= S_INS_CHK;
						end else begin
							state_q <= S_TOP_RD;
						end
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_TOP_RD: state_q <= S_TOP_WT;
				S_TOP_WT: begin
					if (both_q) begin
						med_q <= avg;
					end else begin
						med_q <= (join_side_q == SIDE_UP) ? up_d : lo_d;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_load) begin
						median    <= med_q;
						overflow  <= ovf_q;
						ovf_q     <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(lc_q <= CW'(HALF_CAPACITY)) && (uc_q <= CW'(HALF_CAPACITY)))
		else $error("heap count beyond capacity");
	a_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |->
		((lc_q == uc_q) || (lc_q == uc_q + CW'(1)) || (uc_q == lc_q + CW'(1))))
		else $error("heaps out of balance");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("item accepted while busy");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_CMP) |-> (idx_q < CW'(HALF_CAPACITY)))
		else $error("insert index beyond capacity");
`endif
endmodule
`default_nettype wire

>>> src/rmth_mem.sv
// Heap store of the running median block: one write port, one read port,
// registered read data. No dependencies.
`default_nettype none
module rmth_mem #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> sim/running_median_two_heaps_top_test.sv
// Testbench for running_median_two_heaps_top: directed and random sample items
// checked against a two-queue median predictor. Depends on rmth_pkg and the RTL.
`default_nettype none
module running_median_two_heaps_top_test import rmth_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HalfCap = DefHalfCapacity;
	localparam int SW = DefSampleWidth;
	localparam int WatchLimit = 40 * HalfCap + 2000;
	localparam int RandItems = 120;

	typedef struct packed {
		logic signed [SW-1:0] sample;
		logic                 new_stream;
	} sample_item_t;

	typedef struct packed {
		logic signed [SW-1:0] median;
		logic                 overflow;
	} median_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [SW-1:0] sample = '0;
	logic new_stream = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SW-1:0] median;
	logic overflow;

	running_median_two_heaps_top #(.HALF_CAPACITY(HalfCap), .SAMPLE_WIDTH(SW)) DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.sample(sample), .new_stream(new_stream), .out_valid(out_valid),
		.out_ready(out_ready), .median(median), .overflow(overflow)
	);

	always #10 clk = ~clk;

	sample_item_t pending_items[$];
	median_res_t  expected_medians[$];
	int errors = 0;
	int n_accepted = 0;
	int n_results = 0;
	int n_overflow = 0;
	int n_fresh = 0;
	int idle_cnt = 0;
	int gap_left = 0;
	int stall_left = 0;
	bit hold_send = 1'b0;
	bit in_taken = 1'b0;

	longint lo_vals[$];
	longint up_vals[$];
	longint med_state = 0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic longint lo_top();
		longint m;
		m = lo_vals[0];
		foreach (lo_vals[i]) if (lo_vals[i] > m) m = lo_vals[i];
		return m;
	endfunction

	function automatic longint up_top();
		longint m;
		m = up_vals[0];
		foreach (up_vals[i]) if (up_vals[i] < m) m = up_vals[i];
		return m;
	endfunction

	function automatic longint lo_pop();
		longint m;
		m = lo_top();
		foreach (lo_vals[i]) if (lo_vals[i] == m) begin
			lo_vals.delete(i);
			break;
		end
		return m;
	endfunction

	function automatic longint up_pop();
		longint m;
		m = up_top();
		foreach (up_vals[i]) if (up_vals[i] == m) begin
			up_vals.delete(i);
			break;
		end
		return m;
	endfunction

	function automatic median_res_t predict_median(sample_item_t it);
		median_res_t r;
		longint x;
		x = it.sample;
		r.overflow = 1'b0;
		if (it.new_stream) begin
			lo_vals.delete();
			up_vals.delete();
			med_state = 0;
		end
		if (lo_vals.size() + up_vals.size() >= 2 * HalfCap) begin
			r.overflow = 1'b1;
		end else if (lo_vals.size() == up_vals.size()) begin
			if (x > med_state) begin
				up_vals.insert(up_vals.size(), x);
				med_state = up_top();
			end else begin
				lo_vals.insert(lo_vals.size(), x);
				med_state = lo_top();
			end
		end else begin
			if (lo_vals.size() > up_vals.size()) begin
				if (x > med_state) up_vals.insert(up_vals.size(), x);
				else begin
					up_vals.insert(up_vals.size(), lo_pop());
					lo_vals.insert(lo_vals.size(), x);
				end
			end else begin
				if (x > med_state) begin
					lo_vals.insert(lo_vals.size(), up_pop());
					up_vals.insert(up_vals.size(), x);
				end else lo_vals.insert(lo_vals.size(), x);
			end
			med_state = (lo_top() + up_top()) / 2;
		end
		r.median = med_state[SW-1:0];
		return r;
	endfunction

	task automatic add_item(logic signed [SW-1:0] s, logic ns);
		sample_item_t it;
		it.sample = s;
		it.new_stream = ns;
		pending_items.insert(pending_items.size(), it);
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				in_taken = 1'b0;
				if (pending_items.size() > 0 && !hold_send && gap_left == 0) begin
					in_valid <= 1'b1;
					sample <= pending_items[0].sample;
					new_stream <= pending_items[0].new_stream;
					void'(pending_items.pop_front());
					gap_left = pick_gap();
				end else begin
					in_valid <= 1'b0;
					if (gap_left > 0) gap_left--;
				end
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		median_res_t exp_r;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sample_item_t it;
				it.sample = sample;
				it.new_stream = new_stream;
				in_taken = 1'b1;
				exp_r = predict_median(it);
				expected_medians.insert(expected_medians.size(), exp_r);
				n_accepted++;
				if (exp_r.overflow) n_overflow++;
				if (it.new_stream) n_fresh++;
			end
			if (out_valid && out_ready) begin
				n_results++;
				if (expected_medians.size() == 0) begin
					$display("%0t: result with none expected: median %0d overflow %0b",
						$time, median, overflow);
					errors++;
				end else begin
					exp_r = expected_medians.pop_front();
					if (median !== exp_r.median) begin
						$display("%0t: median expected %0d actual %0d",
							$time, exp_r.median, median);
						errors++;
					end
					if (overflow !== exp_r.overflow) begin
						$display("%0t: overflow expected %0b actual %0b",
							$time, exp_r.overflow, overflow);
						errors++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt = 0;
			else idle_cnt++;
			if (idle_cnt >= WatchLimit) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		int n;
		int k;
		int mode;
		int len;
		bit paused;
		paused = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_item(16'sd0, 1'b0);
		add_item(16'sh7FFF, 1'b0);
		add_item(-16'sd32768, 1'b0);
		add_item(16'sd5, 1'b0);
		add_item(-16'sd5, 1'b0);
		add_item(16'sd5, 1'b0);
		add_item(-16'sd1, 1'b0);
		add_item(16'sh7FFF, 1'b1);
		add_item(16'sh7FFF, 1'b0);
		add_item(-16'sd32768, 1'b1);
		add_item(-16'sd32768, 1'b0);
		add_item(-16'sd32767, 1'b0);
		add_item(16'sd3, 1'b1);
		add_item(-16'sd4, 1'b0);
		add_item(16'sd3, 1'b0);
		add_item(16'sd3, 1'b0);
		add_item(16'sh5555, 1'b0);
		add_item(-16'sh5556, 1'b0);
		wait (pending_items.size() == 0 && !in_valid && expected_medians.size() == 0);

		// fill the store, overflow it, then new stream on a full store
		add_item(SW'($urandom), 1'b1);
		for (k = 1; k < 2 * HalfCap + 4; k++) add_item(SW'($urandom), 1'b0);
		add_item(SW'($urandom), 1'b1);
		add_item(SW'($urandom), 1'b0);

		n = 0;
		while (n < RandItems) begin
			mode = $urandom_range(0, 9);
			len = $urandom_range(1, 30);
			for (k = 0; k < len && n < RandItems; k++) begin
				case (mode)
					0, 1, 2: add_item(SW'($urandom), k == 0);
					3, 4: add_item(SW'($urandom_range(0, 6) - 3), k == 0);
					5: add_item(k[0] ? 16'sh7FFF : -16'sd32768, 1'b0);
					6: add_item(SW'($urandom_range(0, 65535)), $urandom_range(0, 15) == 0);
					default: add_item(SW'($urandom_range(0, 200) - 100), 1'b0);
				endcase
				n++;
			end
			if (!paused && n >= RandItems / 2) begin
				paused = 1'b1;
				wait (pending_items.size() == 0);
				hold_send = 1'b1;
				wait (expected_medians.size() == 0 && !in_valid);
				hold_send = 1'b0;
			end
		end
		wait (pending_items.size() == 0 && !in_valid && expected_medians.size() == 0);
		repeat (4 * HalfCap + 20) @(posedge clk);
		$display("Run took %0d items (%0d new streams, %0d dropped on a full store)",
			n_accepted, n_fresh, n_overflow);
		$display("and checked %0d medians under random gaps and stalls", n_results);
		if (errors == 0 && expected_medians.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> running_median_two_heaps_top.f
src/rmth_pkg.sv
src/rmth_mem.sv
src/running_median_two_heaps_top.sv
sim/running_median_two_heaps_top_test.sv
